@@ sv/gle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gle_pkg
// Widths, constants and the sequencer state type of the gated linear decay
// envelope.
// ----------------------------------------------------------------------------
package gle_pkg;

  localparam int WidthW  = 16;
  localparam int MagW    = WidthW - 1;
  localparam int RateW   = 18;
  localparam int LevelW  = 24;
  localparam int ScaledW = MagW + 4;            // 10 * |w|
  localparam int DivW    = ScaledW + RateW;     // 10 * w * rate
  localparam int StepW   = LevelW - 1;          // quotient bits when div > 2^15
  localparam int CntW    = 5;

  localparam int MulSteps = RateW;
  localparam int DivSteps = StepW;

  localparam logic [RateW-1:0]  RateReset = RateW'(48000);
  localparam logic [LevelW-1:0] LevelOne  = LevelW'(1) << (LevelW - 1);
  // 2^38 / div >= 2^23 exactly when div <= 2^15
  localparam logic [DivW-1:0]   DivFloor  = DivW'(1) << 15;
  localparam logic [DivW-1:0]   RemStart  = DivW'(1) << 15;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

@@ sv/gated_linear_decay_envelope.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_linear_decay_envelope
// Gate-triggered envelope: a rising gate loads 1.0, a held gate decays the
// level linearly by floor(2^38 / (10 * width * sample_rate)), clamped at zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries gate_on and width (Q1.15).
//   Output channel out_valid/out_ready returns one level (Q1.23) per input
//   transfer. sample_rate is written with sample_rate_we; write it only while
//   idle, as the block itself does not enforce this. A rising gate, gate
//   off, empty level, nonpositive width or zero sample_rate skips the
//   arithmetic; a decay step runs through a shift-add multiplier (one rate
//   bit per cycle) and, unless the divisor is at most 2^15, a restoring
//   divider (one quotient bit per cycle), so one item is in flight at a
//   time and in_ready returns in the same cycle as output valid.
//   A finished level waits in the output register; the next input is taken
//   meanwhile, and a new result waits for the register to drain.
//   Reset: envelope level and previous gate clear, sample_rate returns to 48000.
// ----------------------------------------------------------------------------
module gated_linear_decay_envelope (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_rate_we,
  input  logic [gle_pkg::RateW-1:0]  sample_rate,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       gate_on,
  input  logic signed [gle_pkg::WidthW-1:0] width,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gle_pkg::LevelW-1:0] level
);
  import gle_pkg::*;

  state_t              state;
  logic [RateW-1:0]    rate;
  logic                last_gate;
  logic [LevelW-1:0]   envelope;
  logic [LevelW-1:0]   step;
  logic                apply_step;
  logic [CntW-1:0]     cnt;
  logic [DivW-1:0]     acc;
  logic [DivW-1:0]     mcand;
  logic [RateW-1:0]    mplier;
  logic [DivW-1:0]     rem;
  logic [StepW-1:0]    quot;

  logic [MagW-1:0]     mag;
  logic [ScaledW-1:0]  scaled;
  logic                in_xfer;
  logic                rising;
  logic                w_nonpos;
  logic [DivW:0]       trial;
  logic [DivW:0]       diff;
  logic                fits;
  logic [LevelW-1:0]   decayed;
  logic [LevelW-1:0]   level_next;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign rising   = gate_on && !last_gate;
  assign w_nonpos = width[WidthW-1] || (width == '0);
  assign mag      = width[MagW-1:0];
  assign scaled   = ({4'b0, mag} << 3) + ({4'b0, mag} << 1);

  assign trial = {rem, 1'b0};
  assign diff  = trial - {1'b0, acc};
  assign fits  = (trial >= {1'b0, acc});

  assign decayed    = (envelope > step) ? envelope - step : '0;
  assign level_next = apply_step ? decayed : envelope;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RateReset;
    end else if (sample_rate_we) begin
      rate <= sample_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      last_gate  <= 1'b0;
      envelope   <= '0;
      out_valid  <= 1'b0;
      apply_step <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            last_gate  <= gate_on;
            apply_step <= 1'b0;
            if (rising) begin
              envelope <= LevelOne;
              state    <= ST_DONE;
            end else if (gate_on && envelope != '0) begin
              apply_step <= 1'b1;
              if (w_nonpos || rate == '0) begin
                step  <= LevelOne;
                state <= ST_DONE;
              end else begin
                acc    <= '0;
                mcand  <= DivW'(scaled);
                mplier <= rate;
                cnt    <= CntW'(MulSteps - 1);
                state  <= ST_MUL;
              end
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DIV;
            rem   <= RemStart;
            quot  <= '0;
            cnt   <= CntW'(DivSteps - 1);
            // last partial product lands this edge; check on the final sum
            if ((mplier[0] ? acc + mcand : acc) <= DivFloor) begin
              step  <= LevelOne;
              state <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          rem  <= fits ? diff[DivW-1:0] : trial[DivW-1:0];
          quot <= {quot[StepW-2:0], fits};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            step  <= ({quot[StepW-2:0], fits} == '0) ? LevelW'(1)
                     : {1'b0, quot[StepW-2:0], fits};
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            envelope  <= level_next;
            level     <= level_next;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    envelope <= LevelOne)
    else $error("envelope above 1.0");

  a_rise_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && gate_on && !last_gate |=> envelope == LevelOne)
    else $error("rising gate did not load 1.0");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> acc > DivFloor)
    else $error("divider entered with small divisor");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && cnt == '0 |=> state == ST_DONE && step != '0)
    else $error("divider finished without a step");
`endif

endmodule
